// ===== src/cgc_pkg.sv =====
package cgc_pkg;

    localparam int NLIMBS         = 8;
    localparam int LIMB_W         = 32;
    localparam int MOD_W          = 31;
    localparam int RES_W          = 64;
    localparam int MAX_PRIMES_DEF = 8;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_MOD     = 2'd1;
    localparam logic [1:0] ST_NOT_COPRIME = 2'd2;
    localparam logic [1:0] ST_TOO_MANY    = 2'd3;

    typedef enum logic [14:0] {
        S_IDLE = 15'h0001,
        S_RRED = 15'h0002,
        S_PMOD = 15'h0004,
        S_RMOD = 15'h0008,
        S_ECHK = 15'h0010,
        S_DIV  = 15'h0020,
        S_MUL  = 15'h0040,
        S_UPD  = 15'h0080,
        S_INV  = 15'h0100,
        S_TMUL = 15'h0200,
        S_TMOD = 15'h0400,
        S_MACM = 15'h0800,
        S_MACA = 15'h1000,
        S_DONE = 15'h2000,
        S_OUT  = 15'h4000
    } t_state;

endpackage

// ===== src/crt_garner_combine.sv =====
// Garner CRT combiner. Each input item is one congruence (residue, modulus,
// last). Items enter on i_valid/o_stall; o_stall is high from acceptance until
// the item is fully absorbed. The first item of a run seeds the 256-bit
// accumulators; each later item reduces P and R mod m, runs extended Euclid
// and adds P * t to R, then multiplies P by m.
// Each item is worked by one shared bit-serial remainder unit (one bit a
// cycle) and one shared 32x32 multiplier.
// An item marked last is then followed by eight result items on
// o_valid/i_stall, limb 0 first, one per cycle while i_stall is low; the
// output holds while i_stall is high. After limb 7 is taken the block
// clears itself and accepts again.
// Reset (synchronous, active low) clears accumulators, count and status.
// Errors are sticky until the last item of the run; the limbs then read zero.
module crt_garner_combine
    import cgc_pkg::*;
#(
    parameter int MAX_PRIMES = MAX_PRIMES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [RES_W-1:0]    i_residue,
    input  logic [MOD_W-1:0]    i_modulus,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_limb_index,
    output logic [LIMB_W-1:0]   o_residue_limb,
    output logic [LIMB_W-1:0]   o_product_limb,
    output logic [1:0]          o_status,
    output logic                o_final_limb
);

    localparam int CW   = $clog2(MAX_PRIMES + 1);
    localparam int LI_W = $clog2(NLIMBS);

    t_state              r_state;
    logic [LIMB_W-1:0]   r_racc [NLIMBS];
    logic [LIMB_W-1:0]   r_pacc [NLIMBS];
    logic [CW-1:0]       r_count;
    logic [1:0]          r_err;
    logic                r_last;
    logic [MOD_W-1:0]    r_m;
    logic [MOD_W-1:0]    r_rem;
    logic [RES_W-1:0]    r_src;
    logic [MOD_W-1:0]    r_q;
    logic [5:0]          r_bc;
    logic [LI_W-1:0]     r_li;
    logic [LI_W-1:0]     r_oi;
    logic [MOD_W-1:0]    r_rr;
    logic [MOD_W-1:0]    r_rm;
    logic [MOD_W-1:0]    r_r0;
    logic [MOD_W-1:0]    r_r1;
    logic [31:0]         r_s0;
    logic [31:0]         r_s1;
    logic [MOD_W-1:0]    r_inv;
    logic [MOD_W-1:0]    r_diff;
    logic [63:0]         r_prod;
    logic [31:0]         r_carry;
    logic                r_pass;

    logic [MOD_W-1:0]    n_rem;
    logic [RES_W-1:0]    n_src;
    logic [MOD_W-1:0]    n_q;
    logic [31:0]         sh;
    logic [MOD_W-1:0]    div_d;
    logic                ge;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_out;
    logic [31:0]         diff_w;
    logic [31:0]         inv_w;
    logic [63:0]         mac_v;
    logic                accept;

    // shared remainder unit: one bit per cycle
    always_comb begin
        div_d = (r_state == S_DIV) ? r_r1 : r_m;
        sh    = {r_rem, r_src[RES_W-1]};
        ge    = (sh >= {1'b0, div_d});
        n_rem = ge ? MOD_W'(sh - {1'b0, div_d}) : sh[MOD_W-1:0];
        n_src = {r_src[RES_W-2:0], 1'b0};
        n_q   = {r_q[MOD_W-2:0], ge};
    end

    // shared multiplier
    always_comb begin
        case (r_state)
            S_MUL: begin
                mul_a = {1'b0, r_q};
                mul_b = r_s1;
            end
            S_TMUL: begin
                mul_a = {1'b0, r_diff};
                mul_b = {1'b0, r_inv};
            end
            default: begin
                mul_a = r_pacc[r_li];
                mul_b = r_pass ? {1'b0, r_m} : {1'b0, r_rem};
            end
        endcase
        mul_out = mul_a * mul_b;
    end

    always_comb begin
        if (r_rr >= r_rm) begin
            diff_w = {1'b0, r_rr} - {1'b0, r_rm};
        end else begin
            diff_w = {1'b0, r_rr} + {1'b0, r_m} - {1'b0, r_rm};
        end
        inv_w = r_s0[31] ? r_s0 + {1'b0, r_m} : r_s0;
        mac_v = (r_pass ? 64'd0 : {32'd0, r_racc[r_li]}) + r_prod + {32'd0, r_carry};
    end

    assign accept = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_err   <= ST_OK;
            r_oi    <= '0;
            for (int i = 0; i < NLIMBS; i++) begin
                r_racc[i] <= '0;
                r_pacc[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= i_last;
                        r_m    <= i_modulus;
                        r_src  <= i_residue;
                        r_rem  <= '0;
                        r_bc   <= 6'd63;
                        if (r_err != ST_OK) begin
                            r_state <= S_DONE;
                        end else if (r_count >= CW'(MAX_PRIMES)) begin
                            r_err   <= ST_TOO_MANY;
                            r_state <= S_DONE;
                        end else if (i_modulus < MOD_W'(2)) begin
                            r_err   <= ST_BAD_MOD;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RRED;
                        end
                    end
                end
                S_RRED: begin
                    r_rem <= n_rem;
                    r_src <= n_src;
                    r_bc  <= r_bc - 6'd1;
                    if (r_bc == 6'd0) begin
                        r_rr <= n_rem;
                        if (r_count == '0) begin
                            for (int i = 0; i < NLIMBS; i++) begin
                                r_racc[i] <= '0;
                                r_pacc[i] <= '0;
                            end
                            r_racc[0] <= {1'b0, n_rem};
                            r_pacc[0] <= {1'b0, r_m};
                            r_count   <= r_count + CW'(1);
                            r_state   <= S_DONE;
                        end else begin
                            r_rem   <= '0;
                            r_li    <= LI_W'(NLIMBS - 1);
                            r_src   <= {r_pacc[NLIMBS-1], 32'd0};
                            r_bc    <= 6'd31;
                            r_state <= S_PMOD;
                        end
                    end
                end
                S_PMOD, S_RMOD: begin
                    r_rem <= n_rem;
                    r_src <= n_src;
                    r_bc  <= r_bc - 6'd1;
                    if (r_bc == 6'd0) begin
                        r_bc <= 6'd31;
                        if (r_li == '0) begin
                            r_li <= LI_W'(NLIMBS - 1);
                            if (r_state == S_PMOD) begin
                                r_r1    <= n_rem;
                                r_r0    <= r_m;
                                r_s0    <= 32'd0;
                                r_s1    <= 32'd1;
                                r_rem   <= '0;
                                r_src   <= {r_racc[NLIMBS-1], 32'd0};
                                r_state <= S_RMOD;
                            end else begin
                                r_rm    <= n_rem;
                                r_state <= S_ECHK;
                            end
                        end else begin
                            r_li <= r_li - LI_W'(1);
                            if (r_state == S_PMOD) begin
                                r_src <= {r_pacc[r_li - LI_W'(1)], 32'd0};
                            end else begin
                                r_src <= {r_racc[r_li - LI_W'(1)], 32'd0};
                            end
                        end
                    end
                end
                S_ECHK: begin
                    if (r_r1 == '0) begin
                        r_state <= S_INV;
                    end else begin
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_src   <= {r_r0, 33'd0};
                        r_bc    <= 6'(MOD_W - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_src <= n_src;
                    r_q   <= n_q;
                    r_bc  <= r_bc - 6'd1;
                    if (r_bc == 6'd0) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_out;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_s0    <= r_s1;
                    r_s1    <= r_s0 - r_prod[31:0];
                    r_r0    <= r_r1;
                    r_r1    <= r_rem;
                    r_state <= S_ECHK;
                end
                S_INV: begin
                    if (r_r0 != MOD_W'(1)) begin
                        r_err   <= ST_NOT_COPRIME;
                        r_state <= S_DONE;
                    end else begin
                        r_inv   <= inv_w[MOD_W-1:0];
                        r_diff  <= diff_w[MOD_W-1:0];
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    r_src   <= mul_out;
                    r_rem   <= '0;
                    r_bc    <= 6'd63;
                    r_state <= S_TMOD;
                end
                S_TMOD: begin
                    r_rem <= n_rem;
                    r_src <= n_src;
                    r_bc  <= r_bc - 6'd1;
                    if (r_bc == 6'd0) begin
                        r_li    <= '0;
                        r_carry <= '0;
                        r_pass  <= 1'b0;
                        r_state <= S_MACM;
                    end
                end
                S_MACM: begin
                    r_prod  <= mul_out;
                    r_state <= S_MACA;
                end
                S_MACA: begin
                    r_carry <= mac_v[63:32];
                    if (r_pass) begin
                        r_pacc[r_li] <= mac_v[31:0];
                    end else begin
                        r_racc[r_li] <= mac_v[31:0];
                    end
                    if (r_li == LI_W'(NLIMBS - 1)) begin
                        r_li <= '0;
                        if (!r_pass) begin
                            r_pass  <= 1'b1;
                            r_carry <= '0;
                            r_state <= S_MACM;
                        end else begin
                            r_count <= r_count + CW'(1);
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_li    <= r_li + LI_W'(1);
                        r_state <= S_MACM;
                    end
                end
                S_DONE: begin
                    r_oi    <= '0;
                    r_state <= r_last ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if (r_oi == LI_W'(NLIMBS - 1)) begin
                            r_oi    <= '0;
                            r_count <= '0;
                            r_err   <= ST_OK;
                            for (int i = 0; i < NLIMBS; i++) begin
                                r_racc[i] <= '0;
                                r_pacc[i] <= '0;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_oi <= r_oi + LI_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = (r_state == S_OUT);
    assign o_limb_index   = 3'(r_oi);
    assign o_residue_limb = (r_err == ST_OK) ? r_racc[r_oi] : '0;
    assign o_product_limb = (r_err == ST_OK) ? r_pacc[r_oi] : '0;
    assign o_status       = r_err;
    assign o_final_limb   = (r_oi == LI_W'(NLIMBS - 1));

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PRIMES))
        else $error("item count above limit");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_err != ST_OK) |-> (o_residue_limb == '0 && o_product_limb == '0))
        else $error("limbs not zero on error");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_final_limb && !i_stall) |=> (r_count == '0 && r_err == ST_OK))
        else $error("block not cleared after run");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_r1))
        else $error("remainder not below divisor");
`endif

endmodule

// ===== dv/crt_checker.sv =====
module crt_checker
    import cgc_pkg::*;
#(
    parameter int MAX_PRIMES = MAX_PRIMES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_in_stall,
    input  logic [RES_W-1:0]  i_residue,
    input  logic [MOD_W-1:0]  i_modulus,
    input  logic              i_last,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [2:0]        i_limb_index,
    input  logic [LIMB_W-1:0] i_residue_limb,
    input  logic [LIMB_W-1:0] i_product_limb,
    input  logic [1:0]        i_status,
    input  logic              i_final_limb,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [2:0]        idx;
        logic [LIMB_W-1:0] rl;
        logic [LIMB_W-1:0] pl;
        logic [1:0]        st;
        logic              fin;
    } t_limb;

    t_limb             limb_q[$];
    logic [LIMB_W-1:0] r_acc[NLIMBS];
    logic [LIMB_W-1:0] p_acc[NLIMBS];
    int unsigned       n_items;
    logic [1:0]        err;

    function automatic longint unsigned acc_mod(input logic [LIMB_W-1:0] v[NLIMBS],
                                                input longint unsigned m);
        longint unsigned r;
        r = 0;
        for (int i = NLIMBS - 1; i >= 0; i--) r = ((r << 32) | v[i]) % m;
        return r;
    endfunction

    function automatic bit mod_inverse(input longint unsigned a, input longint unsigned m,
                                       output longint unsigned inv);
        longint s0, s1, r0, r1, q, tmp;
        s0 = 0; s1 = 1; r0 = m; r1 = a % m;
        while (r1 != 0) begin
            q = r0 / r1;
            tmp = s0 - q * s1; s0 = s1; s1 = tmp;
            tmp = r0 - q * r1; r0 = r1; r1 = tmp;
        end
        if (s0 < 0) s0 += m;
        inv = s0;
        return r0 == 1;
    endfunction

    task automatic clear_state();
        for (int i = 0; i < NLIMBS; i++) begin
            r_acc[i] = '0;
            p_acc[i] = '0;
        end
        n_items = 0;
        err = ST_OK;
    endtask

    task automatic absorb_item(input logic [RES_W-1:0] res, input longint unsigned m);
        longint unsigned pm, rm, inv, t, v, c, c2;
        if (err != ST_OK) return;
        if (n_items >= MAX_PRIMES) begin
            err = ST_TOO_MANY;
            return;
        end
        if (m < 2) begin
            err = ST_BAD_MOD;
            return;
        end
        if (n_items == 0) begin
            for (int i = 0; i < NLIMBS; i++) begin
                r_acc[i] = '0;
                p_acc[i] = '0;
            end
            r_acc[0] = LIMB_W'(res % m);
            p_acc[0] = LIMB_W'(m);
        end else begin
            pm = acc_mod(p_acc, m);
            rm = acc_mod(r_acc, m);
            if (!mod_inverse(pm, m, inv)) begin
                err = ST_NOT_COPRIME;
                return;
            end
            t = (((res % m) + m - rm) % m) * inv % m;
            c = 0; c2 = 0;
            for (int i = 0; i < NLIMBS; i++) begin
                v = longint'(r_acc[i]) + longint'(p_acc[i]) * t + c;
                r_acc[i] = v[31:0];
                c = v >> 32;
                v = longint'(p_acc[i]) * m + c2;
                p_acc[i] = v[31:0];
                c2 = v >> 32;
            end
        end
        n_items = (n_items + 1) & 31;
    endtask

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        clear_state();
    end

    assign o_pending = limb_q.size();

    always @(posedge i_clk) begin
        t_limb e;
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_valid && !i_in_stall) begin
                absorb_item(i_residue, longint'(i_modulus));
                if (i_last) begin
                    for (int i = 0; i < NLIMBS; i++) begin
                        e.idx = 3'(i);
                        e.rl = (err == ST_OK) ? r_acc[i] : '0;
                        e.pl = (err == ST_OK) ? p_acc[i] : '0;
                        e.st = err;
                        e.fin = (i == NLIMBS - 1);
                        limb_q.push_back(e);
                    end
                    clear_state();
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (limb_q.size() == 0) begin
                    report("unexpected limb");
                end else begin
                    e = limb_q.pop_front();
                    if (i_limb_index !== e.idx)
                        report($sformatf("limb_index %0d exp %0d", i_limb_index, e.idx));
                    if (i_residue_limb !== e.rl)
                        report($sformatf("residue_limb %h exp %h", i_residue_limb, e.rl));
                    if (i_product_limb !== e.pl)
                        report($sformatf("product_limb %h exp %h", i_product_limb, e.pl));
                    if (i_status !== e.st)
                        report($sformatf("status %0d exp %0d", i_status, e.st));
                    if (i_final_limb !== e.fin)
                        report($sformatf("final_limb %0d exp %0d", i_final_limb, e.fin));
                end
            end
        end
    end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import cgc_pkg::*;

    localparam int WATCHDOG = 200000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [RES_W-1:0]  i_residue = '0;
    logic [MOD_W-1:0]  i_modulus = '0;
    logic              i_last = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [2:0]        o_limb_index;
    logic [LIMB_W-1:0] o_residue_limb;
    logic [LIMB_W-1:0] o_product_limb;
    logic [1:0]        o_status;
    logic              o_final_limb;
    int                fail_count;
    int                pending;
    int                send_idle_pct = 33;
    int                recv_idle_pct = 82;
    bit                recv_hold = 1'b0;
    int                quiet_cycles = 0;

    localparam logic [30:0] PRIMES[8] = '{31'h7FFFFFFF, 31'd2147483629, 31'd2147483587,
                                          31'd2147483579, 31'd2147483563, 31'd2147483549,
                                          31'd2147483543, 31'd2147483497};

    always #1 i_clk = ~i_clk;

    crt_garner_combine uut (.*);

    crt_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_residue(i_residue), .i_modulus(i_modulus), .i_last(i_last),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_limb_index(o_limb_index),
        .i_residue_limb(o_residue_limb), .i_product_limb(o_product_limb),
        .i_status(o_status), .i_final_limb(o_final_limb),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send(input logic [RES_W-1:0] r, input logic [MOD_W-1:0] m,
                        input logic l);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_residue <= r;
        i_modulus <= m;
        i_last <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [MOD_W-1:0] rand_mod();
        case ($urandom_range(9))
            0: return MOD_W'($urandom_range(3));
            1: return MOD_W'($urandom);
            2: return MOD_W'($urandom_range(2, 40));
            default: return PRIMES[$urandom_range(7)];
        endcase
    endfunction

    task automatic send_run(input int n, input bit coprime);
        int perm[$];
        for (int i = 0; i < 8; i++) perm.push_back(i);
        perm.shuffle();
        for (int i = 0; i < n; i++)
            send({$urandom, $urandom},
                 (coprime && i < 8) ? PRIMES[perm[i]] : rand_mod(), i == n - 1);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        int sent;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(64'hFFFFFFFFFFFFFFFF, 31'h7FFFFFFF, 1'b1);
        send(64'd0, 31'd2, 1'b1);
        send(64'd5, 31'd0, 1'b1);
        send(64'd5, 31'd1, 1'b1);
        send(64'd7, 31'd6, 1'b0);
        send(64'd9, 31'd4, 1'b1);
        send(64'd3, 31'd5, 1'b0);
        send(64'd3, 31'd5, 1'b1);
        send(64'd1, 31'd3, 1'b0);
        send(64'd1, 31'd0, 1'b0);
        send(64'd1, 31'd9, 1'b1);
        send_run(8, 1'b1);
        send_run(9, 1'b1);
        drain();

        fork
            begin
                recv_hold <= 1'b1;
                repeat (12000) @(posedge i_clk);
                recv_hold <= 1'b0;
            end
            begin
                send_run(3, 1'b1);
                send_run(2, 1'b1);
                send_run(2, 1'b1);
            end
        join
        drain();

        sent = 0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 82 : 0;
            recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 33 : 0;
            for (int k = 0; k < 160; k += sent) begin
                sent = $urandom_range(1, 10);
                send_run(sent, $urandom_range(99) < 80);
                if ($urandom_range(9) == 0) drain();
            end
        end
        drain();
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
